@@ rtl/tgr_pkg.sv @@
// ----------------------------------------------------------------------------
// tgr_pkg
// Shared types, constants and the 5x7 font ROM for the text glyph renderer.
// ----------------------------------------------------------------------------
package tgr_pkg;

    localparam int GLYPH_COLS    = 5;
    localparam int GLYPH_ROWS    = 7;
    localparam int GLYPH_BITS    = GLYPH_COLS * GLYPH_ROWS;
    localparam int COORD_W       = 16;
    localparam int COLOR_W       = 16;
    localparam int SCALE_W       = 8;
    localparam int CFG_IDX_W     = 4;
    localparam int CFG_DATA_W    = 16;
    localparam int S_TDATA_W     = 40;
    localparam int M_TDATA_W     = 80;

    localparam logic [7:0] NEWLINE_CODE = 8'd10;
    localparam logic [7:0] CASE_FOLD    = 8'd32;
    localparam logic [7:0] LOWER_A      = 8'h61;
    localparam logic [7:0] LOWER_Z      = 8'h7a;

    localparam logic [2:0] COL_LAST = 3'(GLYPH_COLS - 1);
    localparam logic [2:0] ROW_LAST = 3'(GLYPH_ROWS - 1);

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FORE_COLOR    = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BACK_COLOR    = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_OPAQUE_BACK   = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE         = 4'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = 4'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 4'd5;
    localparam logic [CFG_IDX_W-1:0] REG_COLUMN_OFFSET = 4'd6;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_OFFSET    = 4'd7;

    localparam logic OP_WRITE_CHAR = 1'b0;
    localparam logic OP_SET_CURSOR = 1'b1;

    typedef struct packed {
        logic load;     // item accepted this cycle
        logic step;     // evaluate current glyph pixel and move on
        logic col_end;  // current pixel is the last row of its column
        logic flush;    // emit the held window as the final one
    } tgr_cmd_t;

    typedef struct packed {
        logic draw;        // accepted item draws a known glyph
        logic stall;       // visible pixel but no room to hand on the held window
        logic pend_valid;  // a window is being held back
        logic out_free;    // output register can take a window
    } tgr_status_t;

    typedef struct packed {
        logic                  found;
        logic [GLYPH_BITS-1:0] bits;
    } glyph_t;

    // columns in order 0..4, each column's bits 0..6 are rows 0..6
    function automatic logic [GLYPH_BITS-1:0] pack5(
        input logic [7:0] c0, input logic [7:0] c1, input logic [7:0] c2,
        input logic [7:0] c3, input logic [7:0] c4);
        return {c4[6:0], c3[6:0], c2[6:0], c1[6:0], c0[6:0]};
    endfunction

    function automatic glyph_t glyph_lookup(input logic [7:0] code_in);
        logic [7:0] code;
        glyph_t     g;
        code    = code_in;
        if (code >= LOWER_A && code <= LOWER_Z) begin
            code = code - CASE_FOLD;
        end
        g.found = 1'b1;
        case (code)
            8'h20: g.bits = pack5(8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
            8'h21: g.bits = pack5(8'h00, 8'h2F, 8'h00, 8'h00, 8'h00);
            8'h25: g.bits = pack5(8'h63, 8'h10, 8'h08, 8'h26, 8'h41);
            8'h28: g.bits = pack5(8'h1C, 8'h22, 8'h41, 8'h00, 8'h00);
            8'h29: g.bits = pack5(8'h00, 8'h00, 8'h41, 8'h22, 8'h1C);
            8'h2B: g.bits = pack5(8'h08, 8'h08, 8'h3E, 8'h08, 8'h08);
            8'h2C: g.bits = pack5(8'h40, 8'h20, 8'h00, 8'h00, 8'h00);
            8'h2D: g.bits = pack5(8'h08, 8'h08, 8'h08, 8'h08, 8'h08);
            8'h2E: g.bits = pack5(8'h60, 8'h60, 8'h00, 8'h00, 8'h00);
            8'h2F: g.bits = pack5(8'h10, 8'h08, 8'h04, 8'h02, 8'h01);
            8'h30: g.bits = pack5(8'h3E, 8'h51, 8'h49, 8'h45, 8'h3E);
            8'h31: g.bits = pack5(8'h00, 8'h42, 8'h7F, 8'h40, 8'h00);
            8'h32: g.bits = pack5(8'h42, 8'h61, 8'h51, 8'h49, 8'h46);
            8'h33: g.bits = pack5(8'h21, 8'h41, 8'h49, 8'h4D, 8'h32);
            8'h34: g.bits = pack5(8'h18, 8'h14, 8'h12, 8'h7F, 8'h10);
            8'h35: g.bits = pack5(8'h27, 8'h45, 8'h45, 8'h45, 8'h39);
            8'h36: g.bits = pack5(8'h3C, 8'h4A, 8'h49, 8'h49, 8'h30);
            8'h37: g.bits = pack5(8'h01, 8'h71, 8'h09, 8'h05, 8'h03);
            8'h38: g.bits = pack5(8'h36, 8'h49, 8'h49, 8'h49, 8'h36);
            8'h39: g.bits = pack5(8'h06, 8'h09, 8'h49, 8'h69, 8'h1E);
            8'h3A: g.bits = pack5(8'h00, 8'h00, 8'h36, 8'h00, 8'h00);
            8'h3D: g.bits = pack5(8'h0A, 8'h0A, 8'h0A, 8'h0A, 8'h0A);
            8'h41: g.bits = pack5(8'h7E, 8'h09, 8'h09, 8'h09, 8'h7E);
            8'h42: g.bits = pack5(8'h7F, 8'h49, 8'h49, 8'h49, 8'h36);
            8'h43: g.bits = pack5(8'h3E, 8'h41, 8'h41, 8'h41, 8'h22);
            8'h44: g.bits = pack5(8'h7F, 8'h41, 8'h41, 8'h41, 8'h3E);
            8'h45: g.bits = pack5(8'h7F, 8'h49, 8'h49, 8'h49, 8'h41);
            8'h46: g.bits = pack5(8'h7F, 8'h09, 8'h09, 8'h09, 8'h01);
            8'h47: g.bits = pack5(8'h3E, 8'h41, 8'h49, 8'h49, 8'h3A);
            8'h48: g.bits = pack5(8'h7F, 8'h08, 8'h08, 8'h08, 8'h7F);
            8'h49: g.bits = pack5(8'h00, 8'h41, 8'h7F, 8'h41, 8'h00);
            8'h4A: g.bits = pack5(8'h20, 8'h40, 8'h40, 8'h41, 8'h3F);
            8'h4B: g.bits = pack5(8'h7F, 8'h08, 8'h14, 8'h22, 8'h41);
            8'h4C: g.bits = pack5(8'h7F, 8'h40, 8'h40, 8'h40, 8'h40);
            8'h4D: g.bits = pack5(8'h7F, 8'h02, 8'h04, 8'h02, 8'h7F);
            8'h4E: g.bits = pack5(8'h7F, 8'h02, 8'h04, 8'h08, 8'h7F);
            8'h4F: g.bits = pack5(8'h3E, 8'h41, 8'h41, 8'h41, 8'h3E);
            8'h50: g.bits = pack5(8'h7F, 8'h09, 8'h09, 8'h09, 8'h06);
            8'h51: g.bits = pack5(8'h3E, 8'h41, 8'h51, 8'h21, 8'h5E);
            8'h52: g.bits = pack5(8'h7F, 8'h09, 8'h19, 8'h29, 8'h46);
            8'h53: g.bits = pack5(8'h46, 8'h49, 8'h49, 8'h49, 8'h31);
            8'h54: g.bits = pack5(8'h01, 8'h01, 8'h7F, 8'h01, 8'h01);
            8'h55: g.bits = pack5(8'h3F, 8'h40, 8'h40, 8'h40, 8'h3F);
            8'h56: g.bits = pack5(8'h1F, 8'h20, 8'h40, 8'h20, 8'h1F);
            8'h57: g.bits = pack5(8'h3F, 8'h40, 8'h38, 8'h40, 8'h3F);
            8'h58: g.bits = pack5(8'h63, 8'h14, 8'h08, 8'h14, 8'h63);
            8'h59: g.bits = pack5(8'h03, 8'h04, 8'h78, 8'h04, 8'h03);
            8'h5A: g.bits = pack5(8'h61, 8'h51, 8'h49, 8'h45, 8'h43);
            default: begin
                g.found = 1'b0;
                g.bits  = '0;
            end
        endcase
        return g;
    endfunction

endpackage

@@ rtl/tgr_ctrl.sv @@
// ----------------------------------------------------------------------------
// tgr_ctrl
// Sequencer: accepts items, walks the 35 glyph pixels, flushes the held window.
// ----------------------------------------------------------------------------
module tgr_ctrl import tgr_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  tgr_status_t status,
    output tgr_cmd_t    cmd
);

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_WALK  = 3'b010,
        ST_FLUSH = 3'b100
    } state_t;

    state_t     state_reg, state_next;
    logic [2:0] col_reg, col_next;
    logic [2:0] row_reg, row_next;

    always_comb begin
        state_next = state_reg;
        col_next   = col_reg;
        row_next   = row_reg;
        s_tready   = 1'b0;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
                if (s_tvalid && status.draw) begin
                    state_next = ST_WALK;
                    col_next   = '0;
                    row_next   = '0;
                end
            end
            ST_WALK: begin
                cmd.col_end = (row_reg == ROW_LAST);
                cmd.step    = !status.stall;
                if (!status.stall) begin
                    if (row_reg == ROW_LAST) begin
                        row_next = '0;
                        col_next = col_reg + 3'd1;
                        if (col_reg == COL_LAST) begin
                            state_next = ST_FLUSH;
                        end
                    end else begin
                        row_next = row_reg + 3'd1;
                    end
                end
            end
            ST_FLUSH: begin
                cmd.flush = status.pend_valid && status.out_free;
                if (!status.pend_valid || status.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            col_reg   <= '0;
            row_reg   <= '0;
        end else begin
            state_reg <= state_next;
            col_reg   <= col_next;
            row_reg   <= row_next;
        end
    end

endmodule

@@ rtl/tgr_dp.sv @@
// ----------------------------------------------------------------------------
// tgr_dp
// Datapath: registers, cursor, glyph pixel walk, clipping, held and output window.
// ----------------------------------------------------------------------------
module tgr_dp import tgr_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_valid,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic [S_TDATA_W-1:0]  s_tdata,
    input  logic                  s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,
    output logic                  m_tlast,
    input  tgr_cmd_t              cmd,
    output tgr_status_t           status
);

    // configuration
    logic [COLOR_W-1:0] fore_color_reg, back_color_reg;
    logic               opaque_back_reg;
    logic [SCALE_W-1:0] scale_reg;
    logic [COORD_W-1:0] screen_width_reg, screen_height_reg;
    logic [COORD_W-1:0] column_offset_reg, row_offset_reg;

    // cursor and walk
    logic [COORD_W-1:0]    cursor_x_reg, cursor_y_reg;
    logic [COORD_W-1:0]    px_reg, py_reg, base_y_reg;
    logic [GLYPH_BITS-1:0] bits_reg;

    // held and output windows
    logic                  pend_valid_reg;
    logic [M_TDATA_W-1:0]  pend_data_reg;
    logic                  m_tvalid_reg, m_tlast_reg;
    logic [M_TDATA_W-1:0]  m_tdata_reg;

    logic [7:0]            char_code;
    logic [COORD_W-1:0]    new_x, new_y;
    glyph_t                glyph;
    logic [SCALE_W-1:0]    s_eff;
    logic [COORD_W-1:0]    adv_x, adv_y;

    logic signed [17:0]    xs, ys, xe, ye, sw_m1, sh_m1;
    logic signed [17:0]    x0, y0, x1, y1;
    logic                  pix_on, vis;
    logic [M_TDATA_W-1:0]  win_data;
    logic [COLOR_W-1:0]    color;
    logic                  out_free;

    assign char_code = s_tdata[7:0];
    assign new_x     = s_tdata[23:8];
    assign new_y     = s_tdata[39:24];
    assign glyph     = glyph_lookup(char_code);

    assign s_eff = (scale_reg == '0) ? SCALE_W'(1) : scale_reg;
    assign adv_x = COORD_W'({s_eff, 2'b00}) + COORD_W'({s_eff, 1'b0});
    assign adv_y = COORD_W'({s_eff, 3'b000});

    // clip the current square against the screen
    assign xs    = {{2{px_reg[15]}}, px_reg};
    assign ys    = {{2{py_reg[15]}}, py_reg};
    assign xe    = xs + $signed({10'd0, s_eff}) - 18'sd1;
    assign ye    = ys + $signed({10'd0, s_eff}) - 18'sd1;
    assign sw_m1 = $signed({2'b00, screen_width_reg}) - 18'sd1;
    assign sh_m1 = $signed({2'b00, screen_height_reg}) - 18'sd1;
    assign x0    = xs[17] ? 18'sd0 : xs;
    assign y0    = ys[17] ? 18'sd0 : ys;
    assign x1    = (xe < sw_m1) ? xe : sw_m1;
    assign y1    = (ye < sh_m1) ? ye : sh_m1;

    assign pix_on = bits_reg[0];
    assign vis    = (pix_on || opaque_back_reg) && (x0 <= x1) && (y0 <= y1);
    assign color  = pix_on ? fore_color_reg : back_color_reg;

    assign win_data = {color,
                       y1[15:0] + row_offset_reg,
                       x1[15:0] + column_offset_reg,
                       y0[15:0] + row_offset_reg,
                       x0[15:0] + column_offset_reg};

    assign out_free = !m_tvalid_reg || m_tready;

    assign status.draw       = (s_tuser == OP_WRITE_CHAR) && (char_code != NEWLINE_CODE)
                               && glyph.found;
    assign status.stall      = vis && pend_valid_reg && !out_free;
    assign status.pend_valid = pend_valid_reg;
    assign status.out_free   = out_free;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fore_color_reg    <= 16'hFFFF;
            back_color_reg    <= 16'h0000;
            opaque_back_reg   <= 1'b0;
            scale_reg         <= 8'd1;
            screen_width_reg  <= 16'd240;
            screen_height_reg <= 16'd240;
            column_offset_reg <= '0;
            row_offset_reg    <= '0;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_FORE_COLOR:    fore_color_reg    <= cfg_data;
                REG_BACK_COLOR:    back_color_reg    <= cfg_data;
                REG_OPAQUE_BACK:   opaque_back_reg   <= cfg_data[0];
                REG_SCALE:         scale_reg         <= cfg_data[SCALE_W-1:0];
                REG_SCREEN_WIDTH:  screen_width_reg  <= cfg_data;
                REG_SCREEN_HEIGHT: screen_height_reg <= cfg_data;
                REG_COLUMN_OFFSET: column_offset_reg <= cfg_data;
                REG_ROW_OFFSET:    row_offset_reg    <= cfg_data;
                default: ;
            endcase
        end
    end

    // cursor update at accept, walk start from the old cursor
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cursor_x_reg <= '0;
            cursor_y_reg <= '0;
        end else if (cmd.load) begin
            if (s_tuser == OP_SET_CURSOR) begin
                cursor_x_reg <= new_x;
                cursor_y_reg <= new_y;
            end else if (char_code == NEWLINE_CODE) begin
                cursor_x_reg <= '0;
                cursor_y_reg <= cursor_y_reg + adv_y;
            end else begin
                cursor_x_reg <= cursor_x_reg + adv_x;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            px_reg     <= cursor_x_reg;
            py_reg     <= cursor_y_reg;
            base_y_reg <= cursor_y_reg;
            bits_reg   <= glyph.bits;
        end else if (cmd.step) begin
            bits_reg <= bits_reg >> 1;
            if (cmd.col_end) begin
                px_reg <= px_reg + COORD_W'(s_eff);
                py_reg <= base_y_reg;
            end else begin
                py_reg <= py_reg + COORD_W'(s_eff);
            end
        end
    end

    // one window is held back so the final one can carry last
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_valid_reg <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            if (cmd.step && vis) begin
                pend_valid_reg <= 1'b1;
            end else if (cmd.flush) begin
                pend_valid_reg <= 1'b0;
            end
            if ((cmd.step && vis && pend_valid_reg) || cmd.flush) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.step && vis) begin
            pend_data_reg <= win_data;
        end
        if ((cmd.step && vis && pend_valid_reg) || cmd.flush) begin
            m_tdata_reg <= pend_data_reg;
            m_tlast_reg <= cmd.flush;
        end
    end

endmodule

@@ rtl/text_glyph_rect_renderer_top.sv @@
// ----------------------------------------------------------------------------
// text_glyph_rect_renderer_top
// 5x7 character generator that turns text into filled display windows.
// ----------------------------------------------------------------------------
// Each input item either moves the text cursor (tuser = 1) or writes one
// character byte (tuser = 0). A written character is folded to upper case,
// looked up in a 48-glyph font ROM and walked column by column, one glyph
// pixel per cycle unless a full output stalls it; every drawn pixel becomes
// a scale x scale square that is clipped to the screen, shifted by the panel
// offsets and sent out as one window item with its fill color. tlast marks
// the final window of a character; a character with no visible square gives
// no items at all. A cursor move, a newline or an unknown character leaves
// the block ready for the next item. A drawn character passes through accept,
// a walk of its 35 pixels and a flush; the pixel walk through the single clip
// unit sets its pace, and a stalled output stretches it.
// Configuration writes are taken every cycle but belong to idle periods.
// ----------------------------------------------------------------------------
module text_glyph_rect_renderer_top import tgr_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    // configuration write channel
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    // input items
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,   // char_code[7:0], new_x[23:8], new_y[39:24]
    input  logic                  s_tuser,   // op
    // window items
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,   // win_x0, win_y0, win_x1, win_y1, fill_color
    output logic                  m_tlast    // last
);

    tgr_cmd_t    cmd;
    tgr_status_t status;

    // registers always take a write
    assign cfg_ready = 1'b1;

    tgr_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    tgr_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cmd       (cmd),
        .status    (status)
    );

    // a cursor move never starts a glyph walk
    a_set_cursor_no_walk: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tuser |=> s_tready)
        else $error("cursor move started a glyph walk");

    // a newline never starts a glyph walk
    a_newline_no_walk: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && !s_tuser && (s_tdata[7:0] == NEWLINE_CODE) |=> s_tready)
        else $error("newline started a glyph walk");

    // the held window is always flushed before the next item is taken
    a_idle_nothing_held: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> !status.pend_valid)
        else $error("window still held while idle");

    // walk and flush never run while the block takes items
    a_no_cmd_when_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> !cmd.step && !cmd.flush)
        else $error("walk command issued while idle");

endmodule
